FILE: hdl/sapc_pkg.sv
// shared types, codes and register defaults for the solenoid arm position controller
package sapc_pkg;

	localparam int TimeW = 32;
	localparam int CfgW  = 12;

	// item commands
	localparam logic [1:0] CMD_TICK    = 2'd0;
	localparam logic [1:0] CMD_TOGGLE  = 2'd1;
	localparam logic [1:0] CMD_REQUEST = 2'd2;

	// player states
	localparam logic [1:0] PLAY_PLAYING = 2'd1;
	localparam logic [1:0] PLAY_PAUSED  = 2'd2;

	// move targets
	localparam logic [1:0] TGT_NONE = 2'd0;
	localparam logic [1:0] TGT_NEAR = 2'd1;
	localparam logic [1:0] TGT_FAR  = 2'd2;

	// move phases
	localparam logic [1:0] PH_NONE    = 2'd0;
	localparam logic [1:0] PH_DRIVE   = 2'd1;
	localparam logic [1:0] PH_CONFIRM = 2'd2;
	localparam logic [1:0] PH_MANUAL  = 2'd3;

	// solenoid commands
	localparam logic [1:0] SOL_NONE = 2'd0;
	localparam logic [1:0] SOL_NEAR = 2'd1;
	localparam logic [1:0] SOL_FAR  = 2'd2;
	localparam logic [1:0] SOL_STOP = 2'd3;

	// playback commands
	localparam logic [1:0] PB_NONE   = 2'd0;
	localparam logic [1:0] PB_PAUSE  = 2'd1;
	localparam logic [1:0] PB_RESUME = 2'd2;

	// notices
	localparam logic [2:0] NOTE_NONE         = 3'd0;
	localparam logic [2:0] NOTE_BUSY         = 3'd1;
	localparam logic [2:0] NOTE_CANNOT_DRIVE = 3'd2;
	localparam logic [2:0] NOTE_NOT_AT_PLAY  = 3'd3;
	localparam logic [2:0] NOTE_START_FAIL   = 3'd4;
	localparam logic [2:0] NOTE_TIMEOUT      = 3'd5;
	localparam logic [2:0] NOTE_SWITCH_FAIL  = 3'd6;

	// completion reports
	localparam logic [1:0] RPT_NONE    = 2'd0;
	localparam logic [1:0] RPT_SUCCESS = 2'd1;
	localparam logic [1:0] RPT_FAILURE = 2'd2;

	// answers
	localparam logic [1:0] ANS_NONE    = 2'd0;
	localparam logic [1:0] ANS_HANDLED = 2'd1;
	localparam logic [1:0] ANS_READY   = 2'd0;
	localparam logic [1:0] ANS_STARTED = 2'd1;
	localparam logic [1:0] ANS_FAILED  = 2'd2;

	// register indexes
	localparam logic [1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [1:0] REG_DRIVE    = 2'd1;
	localparam logic [1:0] REG_SETTLE   = 2'd2;
	localparam logic [1:0] REG_TIMEOUT  = 2'd3;

	localparam logic [CfgW-1:0] DEBOUNCE_RESET = 12'd30;
	localparam logic [CfgW-1:0] DRIVE_RESET    = 12'd220;
	localparam logic [CfgW-1:0] SETTLE_RESET   = 12'd20;
	localparam logic [CfgW-1:0] TIMEOUT_RESET  = 12'd360;

	typedef struct packed {
		logic [CfgW-1:0] debounce_ms;
		logic [CfgW-1:0] drive_ms;
		logic [CfgW-1:0] settle_ms;
		logic [CfgW-1:0] timeout_ms;
	} cfg_t;

	typedef struct packed {
		logic [1:0] cmd;
		logic       hall_near_raw;
		logic       hall_setting_on;
		logic       solenoid_on;
		logic       actions_allowed;
		logic [1:0] player_state;
		logic       driver_busy;
		logic       driver_cmd_ok;
		logic       pause_cmd_ok;
		logic       has_requester;
	} item_t;

	typedef struct packed {
		logic [1:0] solenoid_cmd;
		logic [1:0] playback_cmd;
		logic [2:0] notice_code;
		logic [1:0] completion_report;
		logic [1:0] request_answer;
		logic       arm_near;
		logic       pause_held;
		logic       move_active;
		logic       resume_blocked;
	} result_t;

	typedef struct packed {
		logic [TimeW-1:0] time_now;
		logic             synced;
		logic             last_sample;
		logic [TimeW-1:0] sample_change_time;
		logic             stable_near;
		logic             latched_pause;
		logic [1:0]       move_target;
		logic [1:0]       move_phase;
		logic [TimeW-1:0] move_start_time;
		logic [TimeW-1:0] confirm_start_time;
		logic             confirm_sample;
		logic [TimeW-1:0] confirm_change_time;
		logic             requester_pending;
		logic             suppress_late_edge;
		logic             suppressed_near;
		logic             prev_hall_en;
		logic             prev_sol_en;
	} state_t;

	localparam state_t STATE_RESET = '{
		time_now:            '0,
		synced:              1'b0,
		last_sample:         1'b0,
		sample_change_time:  '0,
		stable_near:         1'b0,
		latched_pause:       1'b0,
		move_target:         TGT_NONE,
		move_phase:          PH_NONE,
		move_start_time:     '0,
		confirm_start_time:  '0,
		confirm_sample:      1'b0,
		confirm_change_time: '0,
		requester_pending:   1'b0,
		suppress_late_edge:  1'b0,
		suppressed_near:     1'b0,
		prev_hall_en:        1'b1,
		prev_sol_en:         1'b1
	};

endpackage

FILE: hdl/sapc_item_if.sv
// input item channel: valid/ready handshake with the item fields
interface sapc_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic       hall_near_raw;
	logic       hall_setting_on;
	logic       solenoid_on;
	logic       actions_allowed;
	logic [1:0] player_state;
	logic       driver_busy;
	logic       driver_cmd_ok;
	logic       pause_cmd_ok;
	logic       has_requester;

	modport source (
		output valid, cmd, hall_near_raw, hall_setting_on, solenoid_on, actions_allowed,
		       player_state, driver_busy, driver_cmd_ok, pause_cmd_ok, has_requester,
		input  ready
	);
	modport sink (
		input  valid, cmd, hall_near_raw, hall_setting_on, solenoid_on, actions_allowed,
		       player_state, driver_busy, driver_cmd_ok, pause_cmd_ok, has_requester,
		output ready
	);
endinterface

FILE: hdl/sapc_result_if.sv
// result item channel: valid/ready handshake with the result fields
interface sapc_result_if;
	logic       valid;
	logic       ready;
	logic [1:0] solenoid_cmd;
	logic [1:0] playback_cmd;
	logic [2:0] notice_code;
	logic [1:0] completion_report;
	logic [1:0] request_answer;
	logic       arm_near;
	logic       pause_held;
	logic       move_active;
	logic       resume_blocked;

	modport source (
		output valid, solenoid_cmd, playback_cmd, notice_code, completion_report,
		       request_answer, arm_near, pause_held, move_active, resume_blocked,
		input  ready
	);
	modport sink (
		input  valid, solenoid_cmd, playback_cmd, notice_code, completion_report,
		       request_answer, arm_near, pause_held, move_active, resume_blocked,
		output ready
	);
endinterface

FILE: hdl/sapc_step.sv
// next-state and result logic for one item
module sapc_step import sapc_pkg::*; (
	input  state_t  st,
	input  item_t   it,
	input  cfg_t    cfg,
	output state_t  nxt,
	output result_t res
);

	function automatic logic at_target(input logic [1:0] tgt, input logic near);
		logic r;
		r = 1'b0;
		if (tgt == TGT_NEAR) r = near;
		else if (tgt == TGT_FAR) r = !near;
		return r;
	endfunction

	function automatic void clear_move(inout state_t x);
		x.move_target         = TGT_NONE;
		x.move_phase          = PH_NONE;
		x.move_start_time     = '0;
		x.confirm_start_time  = '0;
		x.confirm_sample      = 1'b0;
		x.confirm_change_time = '0;
		x.requester_pending   = 1'b0;
	endfunction

	function automatic void cancel_move(inout state_t x, inout result_t r, input logic stop);
		logic had;
		logic req;
		had = x.move_target != TGT_NONE;
		req = x.requester_pending;
		clear_move(x);
		if (stop) r.solenoid_cmd = SOL_STOP;
		if (had && req) r.completion_report = RPT_FAILURE;
	endfunction

	function automatic void sync_all(inout state_t x, input item_t i);
		x.last_sample        = i.hall_near_raw;
		x.stable_near        = i.hall_near_raw;
		x.sample_change_time = x.time_now;
		x.latched_pause      = 1'b0;
		clear_move(x);
		x.suppress_late_edge = 1'b0;
		x.suppressed_near    = 1'b0;
		x.prev_hall_en       = i.hall_setting_on | i.solenoid_on;
		x.prev_sol_en        = i.solenoid_on;
		x.synced             = 1'b1;
	endfunction

	function automatic logic apply_playback(inout state_t x, inout result_t r,
			input logic near, input item_t i);
		logic ok;
		ok = 1'b0;
		if (i.actions_allowed) begin
			if (near && i.player_state != PLAY_PLAYING && i.player_state != PLAY_PAUSED) begin
				x.latched_pause = 1'b1;
				ok = 1'b1;
			end else begin
				r.playback_cmd = near ? PB_PAUSE : PB_RESUME;
				if (i.pause_cmd_ok) begin
					x.latched_pause = near;
					ok = 1'b1;
				end
			end
		end
		return ok;
	endfunction

	function automatic void finish_move(inout state_t x, inout result_t r, input item_t i);
		logic       near;
		logic [1:0] reached;
		logic       req;
		logic       stop;
		near    = x.stable_near;
		reached = x.move_target;
		req     = x.requester_pending;
		stop    = x.move_phase != PH_MANUAL;
		clear_move(x);
		if (stop) r.solenoid_cmd = SOL_STOP;
		if (req) begin
			r.completion_report = (reached == TGT_FAR && !near) ? RPT_SUCCESS : RPT_FAILURE;
		end else if (!apply_playback(x, r, near, i)) begin
			r.notice_code = NOTE_SWITCH_FAIL;
		end
	endfunction

	function automatic void fail_timeout(inout state_t x, inout result_t r);
		logic req;
		req = x.requester_pending;
		x.suppress_late_edge = 1'b1;
		x.suppressed_near    = x.move_target == TGT_NEAR;
		clear_move(x);
		r.solenoid_cmd = SOL_STOP;
		r.notice_code  = NOTE_TIMEOUT;
		if (req) r.completion_report = RPT_FAILURE;
	endfunction

	state_t           s;
	result_t          r;
	logic             hall_en;
	logic             changed;
	logic             go_on;
	logic             conf;
	logic             pause_req;
	logic             near;
	logic [TimeW-1:0] now;
	logic [TimeW-1:0] elapsed;
	logic [TimeW-1:0] debounce_w;
	logic [TimeW-1:0] drive_w;
	logic [TimeW-1:0] settle_w;
	logic [TimeW-1:0] timeout_w;

	assign debounce_w = TimeW'(cfg.debounce_ms);
	assign drive_w    = TimeW'(cfg.drive_ms);
	assign settle_w   = TimeW'(cfg.settle_ms);
	assign timeout_w  = TimeW'(cfg.timeout_ms);

	always_comb begin
		s         = st;
		r         = '0;
		hall_en   = it.hall_setting_on | it.solenoid_on;
		changed   = 1'b0;
		go_on     = 1'b0;
		conf      = 1'b0;
		pause_req = 1'b0;
		near      = 1'b0;
		now       = st.time_now;
		elapsed   = '0;

		case (it.cmd)
			CMD_TICK: begin
				s.time_now = st.time_now + TimeW'(1);
				now = s.time_now;
				if (!s.synced) sync_all(s, it);
				if (it.hall_near_raw != s.last_sample) begin
					s.last_sample = it.hall_near_raw;
					s.sample_change_time = now;
				end
				if (it.hall_near_raw != s.stable_near &&
						(now - s.sample_change_time) >= debounce_w) begin
					s.stable_near = it.hall_near_raw;
					changed = 1'b1;
				end

				if (!it.solenoid_on && s.prev_sol_en) begin
					if (s.move_phase != PH_MANUAL) cancel_move(s, r, 1'b1);
				end else if (it.solenoid_on && !s.prev_sol_en) begin
					if (s.move_phase == PH_MANUAL) cancel_move(s, r, 1'b0);
				end
				s.prev_sol_en = it.solenoid_on;

				if (!hall_en) begin
					if (s.prev_hall_en) begin
						cancel_move(s, r, 1'b1);
						s.latched_pause = 1'b0;
						s.suppress_late_edge = 1'b0;
					end
					s.prev_hall_en = 1'b0;
				end else begin
					if (!s.prev_hall_en) begin
						s.prev_hall_en = 1'b1;
						s.latched_pause = 1'b0;
						s.suppress_late_edge = 1'b0;
					end
					if (s.move_target != TGT_NONE) begin
						if (s.move_phase == PH_MANUAL) begin
							if (!it.actions_allowed) cancel_move(s, r, 1'b0);
							else if (changed && at_target(s.move_target, s.stable_near))
								finish_move(s, r, it);
						end else begin
							elapsed = now - s.move_start_time;
							go_on = 1'b1;
							if (s.move_phase == PH_DRIVE) begin
								if (elapsed < drive_w) begin
									go_on = 1'b0;
								end else begin
									if (it.driver_busy) begin
										r.solenoid_cmd = SOL_STOP;
										if (!it.driver_cmd_ok) begin
											if (elapsed >= timeout_w) fail_timeout(s, r);
											go_on = 1'b0;
										end
									end
									if (go_on) begin
										s.move_phase = PH_CONFIRM;
										s.confirm_start_time = now;
										s.confirm_sample = it.hall_near_raw;
										s.confirm_change_time = now;
									end
								end
							end
							if (go_on) begin
								if (s.move_phase == PH_CONFIRM) begin
									if (it.hall_near_raw != s.confirm_sample) begin
										s.confirm_sample = it.hall_near_raw;
										s.confirm_change_time = now;
									end
									if ((now - s.confirm_start_time) >= settle_w &&
											(now - s.confirm_change_time) >= debounce_w &&
											at_target(s.move_target, s.confirm_sample)) begin
										s.last_sample = s.confirm_sample;
										s.stable_near = s.confirm_sample;
										s.sample_change_time = now;
										conf = 1'b1;
									end
								end
								if (conf) finish_move(s, r, it);
								else if (elapsed >= timeout_w) fail_timeout(s, r);
							end
						end
					end else if (changed) begin
						if (s.suppress_late_edge && s.stable_near == s.suppressed_near) begin
							s.suppress_late_edge = 1'b0;
						end else begin
							s.suppress_late_edge = 1'b0;
							void'(apply_playback(s, r, s.stable_near, it));
						end
					end
				end
			end

			CMD_TOGGLE: begin
				if (!s.synced) sync_all(s, it);
				r.request_answer = ANS_HANDLED;
				if (!it.solenoid_on) begin
					if (!hall_en || it.player_state == PLAY_PLAYING || !s.stable_near)
						r.request_answer = ANS_NONE;
					else
						r.notice_code = NOTE_NOT_AT_PLAY;
				end else if (!it.actions_allowed) begin
					r.notice_code = NOTE_CANNOT_DRIVE;
				end else if (s.move_target != TGT_NONE || it.driver_busy) begin
					r.notice_code = NOTE_BUSY;
				end else begin
					s.suppress_late_edge = 1'b0;
					pause_req = it.player_state == PLAY_PLAYING;
					near = s.stable_near;
					if (pause_req ? near : !near) begin
						if (!apply_playback(s, r, near, it)) r.notice_code = NOTE_SWITCH_FAIL;
					end else begin
						r.solenoid_cmd = pause_req ? SOL_NEAR : SOL_FAR;
						if (!it.driver_cmd_ok) begin
							r.notice_code = NOTE_START_FAIL;
						end else begin
							s.move_target = pause_req ? TGT_NEAR : TGT_FAR;
							s.move_phase = PH_DRIVE;
							s.move_start_time = s.time_now;
							s.confirm_start_time = '0;
							s.requester_pending = 1'b0;
						end
					end
				end
			end

			CMD_REQUEST: begin
				if (!s.synced) sync_all(s, it);
				if (!hall_en) begin
					r.request_answer = ANS_READY;
				end else begin
					r.request_answer = ANS_FAILED;
					if (!it.has_requester) begin
						r.request_answer = ANS_FAILED;
					end else if (!it.actions_allowed) begin
						r.notice_code = NOTE_CANNOT_DRIVE;
					end else if (s.move_target != TGT_NONE || it.driver_busy) begin
						r.notice_code = NOTE_BUSY;
					end else if (!s.stable_near) begin
						r.request_answer = ANS_READY;
					end else if (!it.solenoid_on) begin
						s.move_target = TGT_FAR;
						s.move_phase = PH_MANUAL;
						s.move_start_time = '0;
						s.confirm_start_time = '0;
						s.requester_pending = 1'b1;
						s.suppress_late_edge = 1'b0;
						r.notice_code = NOTE_NOT_AT_PLAY;
						r.request_answer = ANS_STARTED;
					end else begin
						s.suppress_late_edge = 1'b0;
						r.solenoid_cmd = SOL_FAR;
						if (!it.driver_cmd_ok) begin
							r.notice_code = NOTE_START_FAIL;
						end else begin
							s.move_target = TGT_FAR;
							s.move_phase = PH_DRIVE;
							s.move_start_time = s.time_now;
							s.confirm_start_time = '0;
							s.requester_pending = 1'b1;
							r.request_answer = ANS_STARTED;
						end
					end
				end
			end

			default: begin
				s = st;
			end
		endcase

		r.arm_near       = s.stable_near;
		r.pause_held     = s.latched_pause;
		r.move_active    = s.move_target != TGT_NONE;
		r.resume_blocked = s.synced & it.solenoid_on & s.stable_near;

		nxt = s;
		res = r;
	end

endmodule

FILE: hdl/solenoid_arm_position_controller_top.sv
// top level: input register, step logic, state and result registers, config registers
// an accepted item is registered in the input register, and its result then in the result register
// throughput: one item per cycle while the result register is not held; the state update is one pass of the step logic
// an item waits in the input register only while the result register is held
// reset: arst_n clears all controller state and valids and loads the register defaults
module solenoid_arm_position_controller_top import sapc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            wr_en,
	input  logic [1:0]      wr_index,
	input  logic [CfgW-1:0] wr_data,
	sapc_item_if.sink       items,
	sapc_result_if.source   results
);

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	result_t res_nxt;
	logic    valid_s2;
	logic    advance;
	logic    take;

	assign advance     = valid_s1 & (~valid_s2 | results.ready);
	assign items.ready = ~valid_s1 | advance;
	assign take        = items.valid & items.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms <= DEBOUNCE_RESET;
			cfg_q.drive_ms    <= DRIVE_RESET;
			cfg_q.settle_ms   <= SETTLE_RESET;
			cfg_q.timeout_ms  <= TIMEOUT_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_DEBOUNCE: cfg_q.debounce_ms <= wr_data;
				REG_DRIVE:    cfg_q.drive_ms    <= wr_data;
				REG_SETTLE:   cfg_q.settle_ms   <= wr_data;
				REG_TIMEOUT:  cfg_q.timeout_ms  <= wr_data;
				default:      cfg_q             <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= STATE_RESET;
		end else begin
			if (items.ready) valid_s1 <= items.valid;
			if (advance) begin
				state_q  <= state_nxt;
				valid_s2 <= 1'b1;
			end else if (results.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1.cmd             <= items.cmd;
			item_s1.hall_near_raw   <= items.hall_near_raw;
			item_s1.hall_setting_on <= items.hall_setting_on;
			item_s1.solenoid_on     <= items.solenoid_on;
			item_s1.actions_allowed <= items.actions_allowed;
			item_s1.player_state    <= items.player_state;
			item_s1.driver_busy     <= items.driver_busy;
			item_s1.driver_cmd_ok   <= items.driver_cmd_ok;
			item_s1.pause_cmd_ok    <= items.pause_cmd_ok;
			item_s1.has_requester   <= items.has_requester;
		end
		if (advance) res_s2 <= res_nxt;
	end

	sapc_step u_step (
		.st  (state_q),
		.it  (item_s1),
		.cfg (cfg_q),
		.nxt (state_nxt),
		.res (res_nxt)
	);

	assign results.valid             = valid_s2;
	assign results.solenoid_cmd      = res_s2.solenoid_cmd;
	assign results.playback_cmd      = res_s2.playback_cmd;
	assign results.notice_code       = res_s2.notice_code;
	assign results.completion_report = res_s2.completion_report;
	assign results.request_answer    = res_s2.request_answer;
	assign results.arm_near          = res_s2.arm_near;
	assign results.pause_held        = res_s2.pause_held;
	assign results.move_active       = res_s2.move_active;
	assign results.resume_blocked    = res_s2.resume_blocked;

endmodule
